// ===== rtl/core/bbcd_pkg.sv =====
package bbcd_pkg;

  // Shift-add divide by ten for the budget fractions, one step per cycle
  localparam int DIV_W     = 44;
  localparam int DIVC_W    = 3;
  localparam int DIV_STEPS = 8;

  localparam logic [3:0] OP_LOOKUP    = 4'd0;
  localparam logic [3:0] OP_TOUCH     = 4'd1;
  localparam logic [3:0] OP_INSERT    = 4'd2;
  localparam logic [3:0] OP_REMOVE    = 4'd3;
  localparam logic [3:0] OP_FREMOVE   = 4'd4;
  localparam logic [3:0] OP_CLR_UNREF = 4'd5;
  localparam logic [3:0] OP_CLR_ALL   = 4'd6;
  localparam logic [3:0] OP_EVICT     = 4'd7;
  localparam logic [3:0] OP_SET_REFS  = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_REFD = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] CFG_MAX    = 2'd0;
  localparam logic [1:0] CFG_THR    = 2'd1;
  localparam logic [1:0] CFG_EVO    = 2'd2;
  localparam logic [1:0] CFG_MINAGE = 2'd3;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] asset_id;
    logic [15:0] type_tag;
    logic [31:0] size_bytes;
    logic [15:0] ref_count;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  status;
    logic [6:0]  count;
    logic [39:0] usage_bytes;
    logic [6:0]  cached_count;
    logic [6:0]  referenced_count;
    logic [31:0] entry_size;
    logic [15:0] entry_refs;
  } out_item_t;

  typedef struct packed {
    logic [63:0] id;
    logic [15:0] typ;
    logic [31:0] size;
    logic [15:0] refs;
    logic [31:0] stamp;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_EX, S_DIV, S_EVCHK, S_BUILD_RD, S_BUILD_EX,
    S_WALK_RD, S_WALK_SLOT, S_WALK_EX, S_RENUM_RD, S_RENUM_EX, S_APPLY,
    S_PASS_RD, S_PASS_EX, S_RESP
  } state_t;

  typedef struct packed {
    state_t ph;
    logic   load;
    logic   resp_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       last;
    logic       div_last;
    logic       evict_go;
    logic       walk_more;
    logic       walk_stop;
    logic       walk_end;
    logic       empty;
    logic       present;
    logic       free_ok;
    logic       refs_nz;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/core/bbcd_ram.sv =====
module bbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bbcd_ctl.sv =====
module bbcd_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  bbcd_pkg::sts_t sts,
  output bbcd_pkg::cmd_t cmd,
  output logic           in_stall
);
  import bbcd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_FIND_RD;
      S_FIND_RD:   state_nxt = S_FIND_EX;
      S_FIND_EX: begin
        if (sts.last) begin
          state_nxt = (sts.op inside {OP_INSERT, OP_EVICT}) ? S_DIV : S_APPLY;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_DIV:       if (sts.div_last) state_nxt = S_EVCHK;
      S_EVCHK:     state_nxt = (sts.evict_go && !sts.empty) ? S_BUILD_RD : S_APPLY;
      S_BUILD_RD:  state_nxt = S_BUILD_EX;
      S_BUILD_EX: begin
        if (sts.last) begin
          state_nxt = (sts.op == OP_CLR_UNREF) ? S_RENUM_RD : S_WALK_RD;
        end else begin
          state_nxt = S_BUILD_RD;
        end
      end
      S_WALK_RD:   state_nxt = sts.walk_more ? S_WALK_SLOT : S_RENUM_RD;
      S_WALK_SLOT: state_nxt = S_WALK_EX;
      S_WALK_EX:   state_nxt = (sts.walk_stop || sts.walk_end) ? S_RENUM_RD : S_WALK_RD;
      S_RENUM_RD:  state_nxt = S_RENUM_EX;
      S_RENUM_EX: begin
        if (sts.last) begin
          state_nxt = (sts.op == OP_CLR_UNREF) ? S_RESP : S_APPLY;
        end else begin
          state_nxt = S_RENUM_RD;
        end
      end
      S_APPLY: begin
        case (sts.op)
          OP_TOUCH, OP_FREMOVE: state_nxt = sts.present ? S_PASS_RD : S_RESP;
          OP_INSERT: state_nxt = (sts.present || sts.free_ok) ? S_PASS_RD : S_RESP;
          OP_REMOVE: state_nxt = (sts.present && !sts.refs_nz) ? S_PASS_RD : S_RESP;
          OP_CLR_UNREF: state_nxt = sts.empty ? S_RESP : S_BUILD_RD;
          default: state_nxt = S_RESP;
        endcase
      end
      S_PASS_RD:   state_nxt = S_PASS_EX;
      S_PASS_EX:   state_nxt = sts.last ? S_RESP : S_PASS_RD;
      S_RESP:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ph        = state_r;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.resp_load = (state_r == S_RESP) && sts.out_free;
    in_stall      = (state_r != S_IDLE);
  end

endmodule

// ===== rtl/core/bbcd_dp.sv =====
module bbcd_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbcd_pkg::cmd_t      cmd,
  output bbcd_pkg::sts_t      sts,
  input  bbcd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbcd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [39:0]         cfg_data
);
  import bbcd_pkg::*;

  localparam int RW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $bits(slot_t);

  // configuration
  logic [39:0] max_r, thr_r;
  logic        evo_r;
  logic [31:0] minage_r;

  // control state
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [39:0]        total_r, total_nxt;
  logic [CW-1:0]      cached_r, cached_nxt, refd_r, refd_nxt;
  logic               hit_r, hit_nxt, gone_r, gone_nxt, free_ok_r, free_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RW-1:0]      idx_r, idx_nxt;

  // payload state
  in_item_t           item_r, item_nxt;
  logic [RW-1:0]      k_r, k_nxt, ren_c_r, ren_c_nxt, walk_slot_r, walk_slot_nxt;
  logic [CW-1:0]      n0_r, n0_nxt, pass_r_r, pass_r_nxt;
  logic [RW-1:0]      hit_slot_r, hit_slot_nxt, hit_rank_r, hit_rank_nxt;
  logic [RW-1:0]      free_slot_r, free_slot_nxt, pass_s_r, pass_s_nxt;
  slot_t              hit_word_r, hit_word_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   d9_r, d9_nxt, d7_r, d7_nxt;
  logic [DIV_W-1:0]   a9_r, a9_nxt, a7_r, a7_nxt;
  logic [39:0]        q9_r, q9_nxt, q7_r, q7_nxt;
  logic [DIVC_W-1:0]  dcnt_r, dcnt_nxt;
  out_item_t          out_r, out_nxt;

  // memories
  logic          data_we, rank_we, ord_we;
  logic [RW-1:0] data_wa, data_ra, rank_wa, ord_wa, ord_ra;
  slot_t         data_wd, data_q;
  logic [SW-1:0] data_rd;
  logic [RW-1:0] rank_wd, rank_q, ord_wd, ord_q;

  bbcd_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_data (
    .clk(clk), .we(data_we), .waddr(data_wa), .wdata(data_wd),
    .raddr(data_ra), .rdata(data_rd)
  );
  bbcd_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
    .raddr(idx_r), .rdata(rank_q)
  );
  bbcd_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .raddr(ord_ra), .rdata(ord_q)
  );

  assign data_q  = slot_t'(data_rd);
  assign data_ra = (cmd.ph == S_WALK_SLOT) ? ord_q : idx_r;
  assign ord_ra  = (cmd.ph == S_WALK_RD) ? k_r : idx_r;

  // derived terms
  logic [39:0] thr_eff;
  logic [31:0] age;
  logic        present, refs_nz, ins_over, ren_last, last, skip, young, out_free;

  assign thr_eff  = (thr_r != '0) ? thr_r : q9_r;
  assign age      = item_r.now_seconds - data_q.stamp;
  assign present  = hit_r && !gone_r;
  assign refs_nz  = (hit_word_r.refs != '0);
  assign ins_over = ({1'b0, total_r} + 41'(item_r.size_bytes)) > {1'b0, thr_eff};
  assign ren_last = (CW'(idx_r) == n0_r - CW'(1));
  assign last     = (cmd.ph == S_RENUM_EX) ? ren_last : (idx_r == RW'(ENTRIES - 1));
  assign skip     = evo_r && (data_q.refs != '0);
  assign young    = (age < minage_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.op        = item_r.opcode;
    sts.last      = last;
    sts.div_last  = (dcnt_r == DIVC_W'(DIV_STEPS - 1));
    sts.evict_go  = (item_r.opcode == OP_EVICT) ? (total_r >= thr_eff)
                                                : (ins_over && (total_r >= thr_eff));
    sts.walk_more = (total_r > q7_r);
    sts.walk_stop = !skip && young;
    sts.walk_end  = (k_r == '0);
    sts.empty     = (cached_r == '0);
    sts.present   = present;
    sts.free_ok   = free_ok_r;
    sts.refs_nz   = refs_nz;
    sts.out_free  = out_free;
  end

  always_comb begin
    slot_t         nw;
    logic [RW-1:0] ws;
    valid_nxt = valid_r;   total_nxt = total_r;   cached_nxt = cached_r;
    refd_nxt = refd_r;     hit_nxt = hit_r;       gone_nxt = gone_r;
    free_ok_nxt = free_ok_r; out_valid_nxt = out_valid_r; idx_nxt = idx_r;
    item_nxt = item_r;     k_nxt = k_r;           ren_c_nxt = ren_c_r;
    walk_slot_nxt = walk_slot_r; n0_nxt = n0_r;   pass_r_nxt = pass_r_r;
    hit_slot_nxt = hit_slot_r;   hit_rank_nxt = hit_rank_r;
    free_slot_nxt = free_slot_r; pass_s_nxt = pass_s_r;
    hit_word_nxt = hit_word_r;   status_nxt = status_r; cnt_nxt = cnt_r;
    d9_nxt = d9_r; d7_nxt = d7_r; a9_nxt = a9_r; a7_nxt = a7_r;
    q9_nxt = q9_r; q7_nxt = q7_r; dcnt_nxt = dcnt_r; out_nxt = out_r;
    data_we = 1'b0; data_wa = hit_slot_r; data_wd = hit_word_r;
    rank_we = 1'b0; rank_wa = idx_r;      rank_wd = '0;
    ord_we  = 1'b0; ord_wa  = rank_q;     ord_wd  = idx_r;
    nw = hit_word_r;
    ws = walk_slot_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (cmd.ph)
      S_IDLE: begin
        if (cmd.load) begin
          item_nxt = in_data;
          hit_nxt = 1'b0;  gone_nxt = 1'b0;  free_ok_nxt = 1'b0;
          status_nxt = ST_OK;  cnt_nxt = '0;  idx_nxt = '0;
          d9_nxt = {max_r, 3'b000} + DIV_W'(max_r);
          d7_nxt = {max_r, 3'b000} - DIV_W'(max_r);
          dcnt_nxt = '0;
        end
      end
      S_FIND_EX: begin
        if (valid_r[idx_r] && data_q.id == item_r.asset_id
            && data_q.typ == item_r.type_tag) begin
          hit_nxt = 1'b1;  hit_slot_nxt = idx_r;
          hit_word_nxt = data_q;  hit_rank_nxt = rank_q;
        end
        if (!valid_r[idx_r] && !free_ok_r) begin
          free_ok_nxt = 1'b1;  free_slot_nxt = idx_r;
        end
        idx_nxt = last ? '0 : idx_r + RW'(1);
      end
      S_DIV: begin
        // approximate n*0.1 by shifted sums, then fix up from the remainder
        case (dcnt_r)
          DIVC_W'(0): begin
            a9_nxt = (d9_r >> 1) + (d9_r >> 2);
            a7_nxt = (d7_r >> 1) + (d7_r >> 2);
          end
          DIVC_W'(1): begin
            a9_nxt = a9_r + (a9_r >> 4);
            a7_nxt = a7_r + (a7_r >> 4);
          end
          DIVC_W'(2): begin
            a9_nxt = a9_r + (a9_r >> 8);
            a7_nxt = a7_r + (a7_r >> 8);
          end
          DIVC_W'(3): begin
            a9_nxt = a9_r + (a9_r >> 16);
            a7_nxt = a7_r + (a7_r >> 16);
          end
          DIVC_W'(4): begin
            a9_nxt = a9_r + (a9_r >> 32);
            a7_nxt = a7_r + (a7_r >> 32);
          end
          DIVC_W'(5): begin
            a9_nxt = a9_r >> 3;
            a7_nxt = a7_r >> 3;
          end
          DIVC_W'(6): begin
            d9_nxt = d9_r - ((a9_r << 3) + (a9_r << 1));
            d7_nxt = d7_r - ((a7_r << 3) + (a7_r << 1));
          end
          default: begin
            q9_nxt = 40'(a9_r + DIV_W'(d9_r > DIV_W'(9)));
            q7_nxt = 40'(a7_r + DIV_W'(d7_r > DIV_W'(9)));
          end
        endcase
        dcnt_nxt = dcnt_r + DIVC_W'(1);
      end
      S_EVCHK: begin
        n0_nxt = cached_r;
        k_nxt  = RW'(cached_r - CW'(1));
      end
      S_BUILD_EX: begin
        ren_c_nxt = '0;
        if (valid_r[idx_r]) begin
          ord_we = 1'b1;
          // clear-unreferenced drops entries on the same sweep
          if (item_r.opcode == OP_CLR_UNREF && data_q.refs == '0) begin
            valid_nxt[idx_r] = 1'b0;
            total_nxt  = total_r - 40'(data_q.size);
            cached_nxt = cached_r - CW'(1);
            cnt_nxt    = cnt_r + 7'd1;
          end
        end
        idx_nxt = last ? '0 : idx_r + RW'(1);
      end
      S_WALK_SLOT: begin
        walk_slot_nxt = ord_q;
      end
      S_WALK_EX: begin
        if (!skip && !young) begin
          valid_nxt[ws] = 1'b0;
          total_nxt  = total_r - 40'(data_q.size);
          cached_nxt = cached_r - CW'(1);
          if (data_q.refs != '0) refd_nxt = refd_r - CW'(1);
          cnt_nxt = cnt_r + 7'd1;
          if (hit_r && ws == hit_slot_r) gone_nxt = 1'b1;
          if (!free_ok_r || ws < free_slot_r) begin
            free_ok_nxt = 1'b1;  free_slot_nxt = ws;
          end
        end
        k_nxt = k_r - RW'(1);
      end
      S_RENUM_EX: begin
        // compact ranks in old LRU order
        if (valid_r[ord_q]) begin
          rank_we = 1'b1;  rank_wa = ord_q;  rank_wd = ren_c_r;
          if (ord_q == hit_slot_r) hit_rank_nxt = ren_c_r;
          ren_c_nxt = ren_c_r + RW'(1);
        end
        idx_nxt = last ? '0 : idx_r + RW'(1);
      end
      S_APPLY: begin
        case (item_r.opcode)
          OP_LOOKUP: if (!present) status_nxt = ST_MISS;
          OP_TOUCH: begin
            if (!present) begin
              status_nxt = ST_MISS;
            end else begin
              nw.stamp = item_r.now_seconds;
              data_we = 1'b1;  data_wd = nw;
              pass_s_nxt = hit_slot_r;  pass_r_nxt = CW'(hit_rank_r);
            end
          end
          OP_INSERT: begin
            nw.id = item_r.asset_id;   nw.typ = item_r.type_tag;
            nw.size = item_r.size_bytes; nw.refs = '0;
            nw.stamp = item_r.now_seconds;
            data_wd = nw;
            if (present) begin
              data_we = 1'b1;  data_wa = hit_slot_r;
              total_nxt = total_r - 40'(hit_word_r.size) + 40'(item_r.size_bytes);
              if (refs_nz) refd_nxt = refd_r - CW'(1);
              pass_s_nxt = hit_slot_r;  pass_r_nxt = CW'(hit_rank_r);
            end else if (free_ok_r) begin
              data_we = 1'b1;  data_wa = free_slot_r;
              valid_nxt[free_slot_r] = 1'b1;
              cached_nxt = cached_r + CW'(1);
              total_nxt = total_r + 40'(item_r.size_bytes);
              pass_s_nxt = free_slot_r;  pass_r_nxt = cached_r;
            end else begin
              status_nxt = ST_FULL;
            end
          end
          OP_REMOVE, OP_FREMOVE: begin
            if (!present) begin
              status_nxt = ST_MISS;
            end else if (item_r.opcode == OP_REMOVE && refs_nz) begin
              status_nxt = ST_REFD;
            end else begin
              valid_nxt[hit_slot_r] = 1'b0;
              total_nxt  = total_r - 40'(hit_word_r.size);
              cached_nxt = cached_r - CW'(1);
              if (refs_nz) refd_nxt = refd_r - CW'(1);
              cnt_nxt = 7'd1;
              pass_s_nxt = hit_slot_r;  pass_r_nxt = CW'(hit_rank_r);
            end
          end
          OP_CLR_UNREF: n0_nxt = cached_r;
          OP_CLR_ALL: begin
            valid_nxt = '0;  total_nxt = '0;  cnt_nxt = 7'(cached_r);
            cached_nxt = '0;  refd_nxt = '0;
          end
          OP_SET_REFS: begin
            if (!present) begin
              status_nxt = ST_MISS;
            end else begin
              nw.refs = item_r.ref_count;
              data_we = 1'b1;  data_wd = nw;  hit_word_nxt = nw;
              if (refs_nz && item_r.ref_count == '0) refd_nxt = refd_r - CW'(1);
              if (!refs_nz && item_r.ref_count != '0) refd_nxt = refd_r + CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_PASS_EX: begin
        if (item_r.opcode == OP_REMOVE || item_r.opcode == OP_FREMOVE) begin
          if (valid_r[idx_r] && idx_r != pass_s_r && CW'(rank_q) > pass_r_r) begin
            rank_we = 1'b1;  rank_wd = rank_q - RW'(1);
          end
        end else if (idx_r == pass_s_r) begin
          rank_we = 1'b1;  rank_wd = '0;
        end else if (valid_r[idx_r] && CW'(rank_q) < pass_r_r) begin
          rank_we = 1'b1;  rank_wd = rank_q + RW'(1);
        end
        idx_nxt = last ? '0 : idx_r + RW'(1);
      end
      S_RESP: begin
        if (cmd.resp_load) begin
          out_valid_nxt = 1'b1;
          out_nxt.hit = hit_r;
          out_nxt.status = status_r;
          out_nxt.count = cnt_r;
          out_nxt.usage_bytes = total_r;
          out_nxt.cached_count = 7'(cached_r);
          out_nxt.referenced_count = 7'(refd_r);
          out_nxt.entry_size = '0;
          out_nxt.entry_refs = '0;
          case (item_r.opcode)
            OP_INSERT: begin
              if (status_r != ST_FULL) out_nxt.entry_size = item_r.size_bytes;
            end
            OP_REMOVE, OP_CLR_UNREF: begin
              if (present && refs_nz) begin
                out_nxt.entry_size = hit_word_r.size;
                out_nxt.entry_refs = hit_word_r.refs;
              end
            end
            OP_FREMOVE, OP_CLR_ALL: ;
            default: begin
              if (present) begin
                out_nxt.entry_size = hit_word_r.size;
                out_nxt.entry_refs = hit_word_r.refs;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;  thr_r <= '0;  evo_r <= 1'b1;  minage_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX:    max_r    <= cfg_data;
        CFG_THR:    thr_r    <= cfg_data;
        CFG_EVO:    evo_r    <= cfg_data[0];
        CFG_MINAGE: minage_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;  total_r <= '0;  cached_r <= '0;  refd_r <= '0;
      hit_r <= 1'b0;  gone_r <= 1'b0;  free_ok_r <= 1'b0;
      out_valid_r <= 1'b0;  idx_r <= '0;
    end else begin
      valid_r <= valid_nxt;  total_r <= total_nxt;  cached_r <= cached_nxt;
      refd_r <= refd_nxt;  hit_r <= hit_nxt;  gone_r <= gone_nxt;
      free_ok_r <= free_ok_nxt;  out_valid_r <= out_valid_nxt;  idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;  k_r <= k_nxt;  ren_c_r <= ren_c_nxt;
    walk_slot_r <= walk_slot_nxt;  n0_r <= n0_nxt;  pass_r_r <= pass_r_nxt;
    hit_slot_r <= hit_slot_nxt;  hit_rank_r <= hit_rank_nxt;
    free_slot_r <= free_slot_nxt;  pass_s_r <= pass_s_nxt;
    hit_word_r <= hit_word_nxt;  status_r <= status_nxt;  cnt_r <= cnt_nxt;
    d9_r <= d9_nxt;  d7_r <= d7_nxt;  a9_r <= a9_nxt;  a7_r <= a7_nxt;
    q9_r <= q9_nxt;  q7_r <= q7_nxt;  dcnt_r <= dcnt_nxt;  out_r <= out_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cached_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CW'($countones(valid_r)) == cached_r) else $error("cached count drift");
  a_refd_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    refd_r <= cached_r) else $error("referenced count above cached count");
  a_gone_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    gone_r |-> hit_r) else $error("evicted hit without a hit");

endmodule

// ===== rtl/core/byte_budget_lru_cache_directory_unit.sv =====
// Flow: every item first scans the directory for a match, then answers; touch, remove
// and a stored insert add a rank pass. Insert and evict add the divide-by-ten steps
// and a check, plus, when eviction runs, an order build, an LRU walk and a rank
// compaction; clear-unreferenced adds an order build and a rank compaction.
// A new item is taken only once the previous result has been loaded for output.
// Reset (rst_n low, synchronous): directory empty, byte total zero, registers at defaults.
module byte_budget_lru_cache_directory_unit #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbcd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbcd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [39:0]         cfg_data
);
  import bbcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbcd_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .sts(sts), .cmd(cmd),
    .in_stall(in_stall)
  );

  bbcd_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

endmodule
